// ===== sv/rkst_pkg.sv =====
// rkst_pkg: shared constants, types and codes for the keyed slot table
// used by rkst_front, rkst_back and refcounted_keyed_slot_table_core
`default_nettype none

package rkst_pkg;

    localparam int SLOTS      = 64;
    localparam int REF_BITS   = 16;
    localparam int KEY_W      = 52;
    localparam int SLOT_IN_W  = 6;
    localparam int REFS_OUT_W = 16;
    localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    typedef logic [KEY_W-1:0]      key_t;
    typedef logic [SLOT_W-1:0]     slot_t;
    typedef logic [SLOT_IN_W-1:0]  slot_in_t;
    typedef logic [REF_BITS-1:0]   refs_t;
    typedef logic [REFS_OUT_W-1:0] refs_out_t;

    localparam refs_t REF_MAX = {REF_BITS{1'b1}};
    localparam slot_t SLOT_LAST = slot_t'(SLOTS - 1);

    typedef enum logic {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_FREE_PUT = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef struct packed {
        op_t      op;
        key_t     key;
        slot_in_t slot_in;
    } req_t;

    typedef struct packed {
        status_t   status;
        slot_in_t  slot_out;
        refs_out_t refs;
        logic      created;
        logic      released;
    } res_t;

    // classified request as held in the queue
    typedef struct packed {
        op_t      op;
        key_t     key;
        slot_in_t slot_in;
        logic     bad_slot;
    } item_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SCAN,
        BK_TAIL,
        BK_PUT_RD,
        BK_PUT_EX
    } bk_state_t;

endpackage

`default_nettype wire

// ===== sv/rkst_front.sv =====
// rkst_front: request intake, slot range check and a short request queue
// depends on rkst_pkg
`default_nettype none

module rkst_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire rkst_pkg::req_t request,
    output logic               busy,
    input  wire logic          pop,
    output logic               item_vld,
    output rkst_pkg::item_t    item
);
    import rkst_pkg::*;

    item_t              q_mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;
    logic               push;
    item_t              new_item;

    assign busy     = (cnt_reg == QCNT_W'(QDEPTH));
    assign push     = start && !busy;
    assign item_vld = (cnt_reg != '0);
    assign item     = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        new_item.op       = request.op;
        new_item.key      = request.key;
        new_item.slot_in  = request.slot_in;
        new_item.bad_slot = (32'(request.slot_in) >= SLOTS);
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= new_item;
        end
    end

`ifndef ASSERT_OFF
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> cnt_reg != '0)
        else $error("queue pop while empty");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(QDEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

`default_nettype wire

// ===== sv/rkst_back.sv =====
// rkst_back: slot scan, claim, count update and result register
// holds key and count memories and the valid bits; depends on rkst_pkg
`default_nettype none

module rkst_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          item_vld,
    input  wire rkst_pkg::item_t item,
    output logic               pop,
    output logic               done,
    output rkst_pkg::res_t     result
);
    import rkst_pkg::*;

    key_t         key_mem  [SLOTS];
    refs_t        refs_mem [SLOTS];

    bk_state_t    state_reg, state_next;
    item_t        cur_reg, cur_next;
    slot_t        addr_reg, addr_next;
    logic         cmp_vld_reg, cmp_vld_next;
    slot_t        cmp_idx_reg, cmp_idx_next;
    logic         have_free_reg, have_free_next;
    slot_t        free_idx_reg, free_idx_next;
    logic [SLOTS-1:0] vld_reg, vld_next;
    key_t         key_rd_reg;
    refs_t        refs_rd_reg;
    logic         done_reg, done_next;
    res_t         res_reg, res_next;

    logic         rd_en;
    slot_t        rd_addr;
    logic         key_we;
    logic         refs_we;
    slot_t        wr_addr;
    refs_t        refs_wdata;

    logic         cmp_hit;
    logic         free_now;
    logic         free_any;
    slot_t        free_idx;
    slot_t        put_idx;
    logic         put_ok;
    refs_t        refs_dec;

    assign cmp_hit  = cmp_vld_reg && vld_reg[cmp_idx_reg] && (key_rd_reg == cur_reg.key);
    assign free_now = cmp_vld_reg && !vld_reg[cmp_idx_reg];
    assign free_any = have_free_reg || free_now;
    assign free_idx = have_free_reg ? free_idx_reg : cmp_idx_reg;
    assign put_idx  = slot_t'(cur_reg.slot_in);
    assign put_ok   = !cur_reg.bad_slot && vld_reg[put_idx];
    assign refs_dec = refs_t'(refs_rd_reg - 1'b1);
    assign done     = done_reg;
    assign result   = res_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (item_vld)
                begin
                    state_next = (item.op == OP_GET) ? BK_SCAN : BK_PUT_RD;
                end
            end
            BK_SCAN:
            begin
                if (cmp_hit)
                begin
                    state_next = BK_IDLE;
                end
                else if (addr_reg == SLOT_LAST)
                begin
                    state_next = BK_TAIL;
                end
            end
            BK_TAIL:   state_next = BK_IDLE;
            BK_PUT_RD: state_next = BK_PUT_EX;
            BK_PUT_EX: state_next = BK_IDLE;
            default:   state_next = BK_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        pop            = 1'b0;
        cur_next       = cur_reg;
        addr_next      = addr_reg;
        cmp_vld_next   = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        have_free_next = have_free_reg;
        free_idx_next  = free_idx_reg;
        vld_next       = vld_reg;
        rd_en          = 1'b0;
        rd_addr        = addr_reg;
        key_we         = 1'b0;
        refs_we        = 1'b0;
        wr_addr        = cmp_idx_reg;
        refs_wdata     = refs_rd_reg;
        done_next      = 1'b0;
        res_next       = res_reg;

        unique case (state_reg)
            BK_IDLE:
            begin
                pop = item_vld;
                if (item_vld)
                begin
                    cur_next       = item;
                    addr_next      = '0;
                    have_free_next = 1'b0;
                end
            end
            BK_SCAN, BK_TAIL:
            begin
                if (state_reg == BK_SCAN)
                begin
                    rd_en        = 1'b1;
                    rd_addr      = addr_reg;
                    cmp_vld_next = !cmp_hit;
                    cmp_idx_next = addr_reg;
                    addr_next    = slot_t'(addr_reg + 1'b1);
                end
                if (free_now && !have_free_reg)
                begin
                    have_free_next = 1'b1;
                    free_idx_next  = cmp_idx_reg;
                end
                res_next.created  = 1'b0;
                res_next.released = 1'b0;
                if (cmp_hit)
                begin
                    done_next         = 1'b1;
                    res_next.slot_out = slot_in_t'(cmp_idx_reg);
                    if (refs_rd_reg == REF_MAX)
                    begin
                        res_next.status = ST_OVERFLOW;
                        res_next.refs   = refs_out_t'(refs_rd_reg);
                    end
                    else
                    begin
                        refs_we         = 1'b1;
                        wr_addr         = cmp_idx_reg;
                        refs_wdata      = refs_t'(refs_rd_reg + 1'b1);
                        res_next.status = ST_OK;
                        res_next.refs   = refs_out_t'(refs_wdata);
                    end
                end
                else if (state_reg == BK_TAIL)
                begin
                    done_next = 1'b1;
                    if (free_any)
                    begin
                        key_we             = 1'b1;
                        refs_we            = 1'b1;
                        wr_addr            = free_idx;
                        refs_wdata         = refs_t'(1);
                        vld_next[free_idx] = 1'b1;
                        res_next.status    = ST_OK;
                        res_next.slot_out  = slot_in_t'(free_idx);
                        res_next.refs      = refs_out_t'(1);
                        res_next.created   = 1'b1;
                    end
                    else
                    begin
                        res_next.status   = ST_FULL;
                        res_next.slot_out = '0;
                        res_next.refs     = '0;
                    end
                end
            end
            BK_PUT_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = put_idx;
            end
            BK_PUT_EX:
            begin
                done_next         = 1'b1;
                res_next.slot_out = cur_reg.slot_in;
                res_next.created  = 1'b0;
                res_next.released = 1'b0;
                if (!put_ok)
                begin
                    res_next.status = ST_FREE_PUT;
                    res_next.refs   = '0;
                end
                else
                begin
                    res_next.status = ST_OK;
                    res_next.refs   = refs_out_t'(refs_dec);
                    if (refs_dec == '0)
                    begin
                        vld_next[put_idx] = 1'b0;
                        res_next.released = 1'b1;
                    end
                    else
                    begin
                        refs_we    = 1'b1;
                        wr_addr    = put_idx;
                        refs_wdata = refs_dec;
                    end
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            cmp_vld_reg   <= 1'b0;
            have_free_reg <= 1'b0;
            vld_reg       <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmp_vld_reg   <= cmp_vld_next;
            have_free_reg <= have_free_next;
            vld_reg       <= vld_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        addr_reg     <= addr_next;
        cmp_idx_reg  <= cmp_idx_next;
        free_idx_reg <= free_idx_next;
        res_reg      <= res_next;
    end

    // key and count memories
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[wr_addr] <= cur_reg.key;
        end
        if (rd_en)
        begin
            key_rd_reg <= key_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (refs_we)
        begin
            refs_mem[wr_addr] <= refs_wdata;
        end
        if (rd_en)
        begin
            refs_rd_reg <= refs_mem[rd_addr];
        end
    end

`ifndef ASSERT_OFF
    a_done_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg) != BK_IDLE)
        else $error("result without work in progress");
    a_created_valid: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && res_reg.created |-> vld_reg[slot_t'(res_reg.slot_out)])
        else $error("claimed slot not marked valid");
    a_released_free: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && res_reg.released |-> !vld_reg[slot_t'(res_reg.slot_out)])
        else $error("released slot still valid");
`endif

endmodule

`default_nettype wire

// ===== sv/refcounted_keyed_slot_table_core.sv =====
// refcounted_keyed_slot_table_core: top level of the keyed slot table
// instantiates rkst_front and rkst_back; depends on rkst_pkg
`default_nettype none

// A request is taken when start is high and busy is low; up to two requests
// wait in a queue while the engine works. Each request gives exactly one
// result, shown on result for one cycle with done high; the receiver cannot
// stall it. A get scans the key memory one slot per cycle through its single
// read port, on to the last slot when the key is new or the table is full,
// and stops early on a hit. A put reads the slot's count and then updates
// it. Requests are served strictly in order.
module refcounted_keyed_slot_table_core (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire rkst_pkg::req_t request,
    output logic           busy,
    output logic           done,
    output rkst_pkg::res_t result
);
    import rkst_pkg::*;

    logic  pop;
    logic  item_vld;
    item_t item;

    rkst_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .request  (request),
        .busy     (busy),
        .pop      (pop),
        .item_vld (item_vld),
        .item     (item)
    );

    rkst_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .item_vld (item_vld),
        .item     (item),
        .pop      (pop),
        .done     (done),
        .result   (result)
    );

endmodule

`default_nettype wire
